/* rtl/dpt_pkg.sv */
package dpt_pkg;

   localparam int OFFSET_BITS = 12;
   localparam int PAGE_BITS   = 8;
   localparam int FRAME_BITS  = 6;
   localparam int PAGE_COUNT  = 1 << PAGE_BITS;
   localparam int FRAME_COUNT = 1 << FRAME_BITS;
   localparam int VA_BITS     = 20;
   localparam int PA_BITS     = FRAME_BITS + OFFSET_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOOK = 2'b10
   } state_type;

endpackage

/* rtl/demand_paging_translator.sv */
// Virtual-to-physical translator with demand paging. An address is taken when start is high
// and busy is low. The next cycle is a lookup cycle with busy high; in the cycle after that,
// rsp_strobe is high for one cycle with the result. A new address may be given while the
// previous result is on the rsp_ ports. The page-frame and frame-owner memories have
// registered reads. Both are read in the accept cycle, and any update is written back at
// the end of the lookup cycle. The receiver cannot stall, so each result must be captured
// in its strobe cycle. On a fault, the lowest free frame is used. Frames are handed out in
// rising order and are never released, so a fill counter tracks them. Once every frame is
// in use, req_victim_frame names the frame to reclaim. The page that owned it is
// invalidated and reported in rsp_evicted_page.
module demand_paging_translator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dpt_pkg::VA_BITS-1:0]    req_virtual_address,
   input  logic [dpt_pkg::FRAME_BITS-1:0] req_victim_frame,
   output logic                           rsp_strobe,
   output logic [dpt_pkg::PA_BITS-1:0]    rsp_physical_address,
   output logic                           rsp_page_fault,
   output logic                           rsp_evicted,
   output logic [dpt_pkg::PAGE_BITS-1:0]  rsp_evicted_page
);
   import dpt_pkg::*;

   state_type state_ff, state_in;

   logic [PAGE_BITS-1:0]   page_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [FRAME_BITS-1:0]  victim_ff;

   logic [FRAME_BITS-1:0]  page_frame_mem [PAGE_COUNT];
   logic [PAGE_BITS-1:0]   frame_owner_mem [FRAME_COUNT];
   logic [FRAME_BITS-1:0]  frame_rd_ff;
   logic [PAGE_BITS-1:0]   owner_rd_ff;

   logic [PAGE_COUNT-1:0]  page_valid_ff, page_valid_in;
   logic [FRAME_BITS:0]    free_count_ff, free_count_in;

   logic                   rsp_strobe_ff;
   logic [PA_BITS-1:0]     rsp_pa_ff, rsp_pa_in;
   logic                   rsp_fault_ff, rsp_fault_in;
   logic                   rsp_evicted_ff, rsp_evicted_in;
   logic [PAGE_BITS-1:0]   rsp_evpage_ff, rsp_evpage_in;

   logic                   accept;
   logic                   look;
   logic                   hit;
   logic                   frames_full;
   logic                   map_write;
   logic [FRAME_BITS-1:0]  frame_sel;

   assign accept      = start && (state_ff == ST_IDLE);
   assign look        = (state_ff == ST_LOOK);
   assign hit         = page_valid_ff[page_ff];
   assign frames_full = free_count_ff[FRAME_BITS];
   assign map_write   = look && !hit;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      page_valid_in  = page_valid_ff;
      free_count_in  = free_count_ff;
      rsp_fault_in   = 1'b0;
      rsp_evicted_in = 1'b0;
      rsp_evpage_in  = '0;
      frame_sel      = frame_rd_ff;
      if (!hit) begin
         rsp_fault_in = 1'b1;
         if (frames_full) begin
            frame_sel      = victim_ff;
            rsp_evicted_in = 1'b1;
            rsp_evpage_in  = owner_rd_ff;
         end else begin
            frame_sel = free_count_ff[FRAME_BITS-1:0];
         end
      end
      if (map_write) begin
         if (frames_full) begin
            page_valid_in[owner_rd_ff] = 1'b0;
         end else begin
            free_count_in = free_count_ff + 1'b1;
         end
         page_valid_in[page_ff] = 1'b1;
      end
      rsp_pa_in = {frame_sel, offset_ff};
   end

   // Both tables are read in the accept cycle and written back at the end of the lookup
   // cycle, so a following item's read always sees the update.
   always_ff @(posedge clock) begin
      if (accept) begin
         frame_rd_ff <= page_frame_mem[req_virtual_address[OFFSET_BITS +: PAGE_BITS]];
         owner_rd_ff <= frame_owner_mem[req_victim_frame];
      end
      if (map_write) begin
         page_frame_mem[page_ff]    <= frame_sel;
         frame_owner_mem[frame_sel] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff   <= req_virtual_address[OFFSET_BITS +: PAGE_BITS];
         offset_ff <= req_virtual_address[OFFSET_BITS-1:0];
         victim_ff <= req_victim_frame;
      end
      if (look) begin
         rsp_pa_ff      <= rsp_pa_in;
         rsp_fault_ff   <= rsp_fault_in;
         rsp_evicted_ff <= rsp_evicted_in;
         rsp_evpage_ff  <= rsp_evpage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         page_valid_ff <= '0;
         free_count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         page_valid_ff <= page_valid_in;
         free_count_ff <= free_count_in;
         rsp_strobe_ff <= look;
      end
   end

   assign busy                 = look;
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_evicted          = rsp_evicted_ff;
   assign rsp_evicted_page     = rsp_evpage_ff;

   a_look_one_cycle: assert property (@(posedge clock) disable iff (reset)
      look |=> !look)
      else $error("lookup lasted more than one cycle");

   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("accepted beat produced no result");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(look))
      else $error("result strobe without a lookup");

   a_evict_is_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_evicted |-> rsp_page_fault && frames_full)
      else $error("eviction without a fault on a full frame pool");

   a_free_count_range: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= (FRAME_BITS + 1)'(FRAME_COUNT))
      else $error("free frame counter overran");

endmodule

/* tb/sv/dpt_tb_pkg.sv */
package dpt_tb_pkg;

   import dpt_pkg::*;

   typedef struct packed {
      logic [PA_BITS-1:0]   physical_address;
      logic                 page_fault;
      logic                 evicted;
      logic [PAGE_BITS-1:0] evicted_page;
   } translation_t;

   class page_table_scoreboard;
      bit                    page_valid [PAGE_COUNT];
      logic [FRAME_BITS-1:0] page_frame [PAGE_COUNT];
      logic [PAGE_BITS-1:0]  frame_owner [FRAME_COUNT];
      bit                    frame_free [FRAME_COUNT];
      int                    frames_used;
      translation_t          expected_translations [$];
      int                    mismatch_count;
      int                    translation_count;
      int                    fault_count;
      int                    eviction_count;

      function new();
         foreach (page_valid[i]) begin
            page_valid[i] = 1'b0;
            page_frame[i] = '0;
         end
         foreach (frame_free[i]) begin
            frame_free[i]  = 1'b1;
            frame_owner[i] = '0;
         end
         frames_used       = 0;
         mismatch_count    = 0;
         translation_count = 0;
         fault_count       = 0;
         eviction_count    = 0;
      endfunction

      // Runs the page table for one accepted request beat and queues the translation.
      function void note_request(logic [VA_BITS-1:0] va, logic [FRAME_BITS-1:0] victim);
         translation_t          t;
         logic [PAGE_BITS-1:0]  page;
         logic [PAGE_BITS-1:0]  old_page;
         logic [FRAME_BITS-1:0] frame;
         bit                    found;
         t     = '0;
         page  = va[OFFSET_BITS +: PAGE_BITS];
         frame = victim;
         found = 1'b0;
         if (page_valid[page]) begin
            frame = page_frame[page];
         end else begin
            t.page_fault = 1'b1;
            for (int i = 0; i < FRAME_COUNT; i++) begin
               if (!found && frame_free[i]) begin
                  found = 1'b1;
                  frame = FRAME_BITS'(i);
               end
            end
            if (found) begin
               frame_free[frame] = 1'b0;
               frames_used++;
            end else begin
               old_page             = frame_owner[frame];
               page_valid[old_page] = 1'b0;
               t.evicted            = 1'b1;
               t.evicted_page       = old_page;
            end
            frame_owner[frame] = page;
            page_frame[page]   = frame;
            page_valid[page]   = 1'b1;
         end
         t.physical_address = {frame, va[OFFSET_BITS-1:0]};
         expected_translations.push_back(t);
      endfunction

      // Frames are handed out from zero upward and never freed, so every frame below
      // frames_used belongs to a page that is currently mapped.
      function logic [PAGE_BITS-1:0] pick_mapped_page();
         if (frames_used == 0) return PAGE_BITS'($urandom_range(0, PAGE_COUNT - 1));
         return frame_owner[$urandom_range(0, frames_used - 1)];
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         $display("MISMATCH: %s", what);
      endtask

      task check_response(logic [PA_BITS-1:0] pa, logic fault, logic ev,
                          logic [PAGE_BITS-1:0] ev_page);
         translation_t want;
         if (expected_translations.size() == 0) begin
            report_mismatch($sformatf("result beat pa=%h with no translation pending", pa));
            return;
         end
         want = expected_translations.pop_front();
         translation_count++;
         fault_count    += want.page_fault;
         eviction_count += want.evicted;
         if (pa !== want.physical_address)
            report_mismatch($sformatf("#%0d physical_address %h, want %h",
                                      translation_count, pa, want.physical_address));
         if (fault !== want.page_fault)
            report_mismatch($sformatf("#%0d page_fault %b, want %b",
                                      translation_count, fault, want.page_fault));
         if (ev !== want.evicted)
            report_mismatch($sformatf("#%0d evicted %b, want %b",
                                      translation_count, ev, want.evicted));
         if (ev_page !== want.evicted_page)
            report_mismatch($sformatf("#%0d evicted_page %h, want %h",
                                      translation_count, ev_page, want.evicted_page));
      endtask
   endclass

endpackage

/* tb/sv/tb_demand_paging_translator.sv */
module tb_demand_paging_translator;

   import dpt_pkg::*;
   import dpt_tb_pkg::*;

   localparam int ITEM_TOTAL     = 1850;
   localparam int DRAIN_EVERY    = 450;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [VA_BITS-1:0]     req_virtual_address = '0;
   logic [FRAME_BITS-1:0]  req_victim_frame = '0;
   logic                   rsp_strobe;
   logic [PA_BITS-1:0]     rsp_physical_address;
   logic                   rsp_page_fault;
   logic                   rsp_evicted;
   logic [PAGE_BITS-1:0]   rsp_evicted_page;

   page_table_scoreboard sb;
   int requests_sent = 0;
   int drain_count   = 0;

   demand_paging_translator u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_virtual_address  (req_virtual_address),
      .req_victim_frame     (req_victim_frame),
      .rsp_strobe           (rsp_strobe),
      .rsp_physical_address (rsp_physical_address),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_evicted          (rsp_evicted),
      .rsp_evicted_page     (rsp_evicted_page)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Holds start high until the beat is taken at an edge where busy is low.
   task automatic send_request(input logic [VA_BITS-1:0] va, input logic [FRAME_BITS-1:0] victim);
      start               <= 1'b1;
      req_virtual_address <= va;
      req_victim_frame    <= victim;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(va, victim);
      requests_sent++;
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start               <= 1'b0;
         req_virtual_address <= VA_BITS'($urandom);
         req_victim_frame    <= FRAME_BITS'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_translations();
      start <= 1'b0;
      drain_count++;
      while (sb.expected_translations.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_response(rsp_physical_address, rsp_page_fault, rsp_evicted, rsp_evicted_page);
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Watchdog: no beat in either direction for %0d cycles.", WATCHDOG_LIMIT);
      $display("** demand_paging_translator: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int                    burst;
      int                    sel;
      logic [PAGE_BITS-1:0]  page;
      logic [OFFSET_BITS-1:0] offset;
      logic [FRAME_BITS-1:0] victim;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: offset and page extremes, first faults and hits, victim extremes while
      // frames are still free (the victim must be ignored then).
      send_request(20'h00000, 6'd0);
      send_request(20'h00fff, 6'd63);
      send_request(20'hfffff, 6'd63);
      send_request(20'hff000, 6'd0);
      send_request(20'h80800, 6'd21);
      send_request(20'h7f7ff, 6'd42);
      send_request(20'h01000, 6'd63);
      send_request(20'h00abc, 6'd0);
      send_request(20'hffabc, 6'd1);
      send_request(20'h55555, 6'h2a);
      send_request(20'haaaaa, 6'h15);
      send_request(20'h55000, 6'd62);
      drain_translations();

      // Random: mostly pages that are mapped or from a hot set a bit larger than the
      // frame pool, so hits, refaults on evicted pages and evictions all mix.
      while (requests_sent < ITEM_TOTAL) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && requests_sent < ITEM_TOTAL; k++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) page = sb.pick_mapped_page();
            else if (sel < 7) page = PAGE_BITS'($urandom_range(0, FRAME_COUNT + 8));
            else page = PAGE_BITS'($urandom);
            case ($urandom_range(0, 7))
               0: offset = '0;
               1: offset = '1;
               default: offset = OFFSET_BITS'($urandom);
            endcase
            case ($urandom_range(0, 7))
               0: victim = '0;
               1: victim = '1;
               default: victim = FRAME_BITS'($urandom);
            endcase
            send_request({page, offset}, victim);
            if (requests_sent % DRAIN_EVERY == 0) drain_translations();
         end
         idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end

      start <= 1'b0;
      while (sb.expected_translations.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Checked %0d translations: %0d page faults, %0d of them evicting a page.",
               sb.translation_count, sb.fault_count, sb.eviction_count);
      $display("Requests came in random bursts with gaps, with %0d full drains.", drain_count);
      if (sb.mismatch_count == 0) begin
         $display("** demand_paging_translator: PASSED **");
      end else begin
         $display("** demand_paging_translator: FAILED **");
      end
      $finish;
   end

endmodule
